// ===== rtl/dmf_pkg.sv =====
`timescale 1ns / 1ps
package dmf_pkg;
	localparam int FRAME_BYTES_DEF = 128;
	localparam int LINE_BYTES_DEF  = 256;
	localparam int STORE_DEPTH     = 256;
	localparam int STORE_AW        = 8;

	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_START = 8'h3e;

	localparam logic [63:0] PFX_SETDATA = 64'h2061746164746573;
	localparam logic [55:0] PFX_MATCH   = 56'h20686374616d25;

	localparam logic [6:0]  NAME_MAX  = 7'd100;
	localparam logic [32:0] TOTAL_MAX = 33'd109;

	typedef enum logic [1:0] {PART_HDR = 2'd0, PART_NAME = 2'd1, PART_VALUE = 2'd2} part_t;
	typedef enum logic [1:0] {
		KIND_BIN = 2'd0, KIND_SET = 2'd1, KIND_MATCH = 2'd2, KIND_OTHER = 2'd3
	} kind_t;
	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_BAD_NAME = 2'd1, ST_TOO_LONG = 2'd2, ST_IGNORED = 2'd3
	} status_t;
	typedef enum logic [1:0] {MODE_IDLE, MODE_BIN, MODE_TEXT} mode_t;
	typedef enum logic [2:0] {
		SQ_RX, SQ_FA, SQ_FD, SQ_HDR, SQ_WA, SQ_WD, SQ_WE
	} seq_t;
endpackage

// ===== rtl/dmf_store.sv =====
`timescale 1ns / 1ps
module dmf_store import dmf_pkg::*; (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [STORE_AW-1:0] wr_addr,
	input  logic [7:0]          wr_data,
	input  logic                rd_en,
	input  logic [STORE_AW-1:0] rd_addr,
	output logic [7:0]          rd_data
);
	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/dual_mode_binary_text_framer_core.sv =====
`timescale 1ns / 1ps
// Serial framer: bytes are written into a 256-byte store as they arrive, one per cycle
// while in_ready is high. At the end of a binary frame or text line the block stops taking
// bytes and a sequencer reads the store back one byte at a time, each registered read taking
// an address state and then a data state. A binary frame fetches its 18 header bytes and a
// text line its 8-byte prefix; the sequencer then emits a header item and, for a good frame
// or a setdata or match line, reads the payload bytes into words and emits each word,
// waiting while the output is stalled. A rejected frame or an ignored line emits only its
// header.
module dual_mode_binary_text_framer_core import dmf_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int LINE_BYTES  = LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  part,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [6:0]  name_length,
	output logic [63:0] stamp,
	output logic [31:0] data_type,
	output logic [7:0]  payload_length,
	output logic [63:0] word,
	output logic [3:0]  word_bytes,
	output logic        last
);
	localparam int LINE_LIMIT = (LINE_BYTES < 256) ? LINE_BYTES : 256;
	localparam logic [8:0] FRAME_N  = 9'(FRAME_BYTES);
	localparam logic [8:0] LINE_TOP = 9'(LINE_LIMIT - 1);

	seq_t          sq_q, sq_d;
	mode_t         mode_q;
	logic [7:0]    cnt_q;
	logic [7:0]    len_q;
	logic          txt_q;
	logic [4:0]    f_q;
	logic [143:0]  acc_q;
	logic [15:0]   nlen_q;
	logic          zero_q;
	logic [8:0]    w_addr_q;
	logic [7:0]    rem_q;
	logic [3:0]    wb_q;
	logic [63:0]   w_acc_q;
	part_t         rpart_q;
	kind_t         rkind_q;

	logic          rx_acc, eol, ld;
	logic          wr_en, rd_en;
	logic [7:0]    wr_addr, rd_addr, rd_data, rbyte;
	logic [8:0]    fa_addr;
	logic [31:0]   dlen;
	logic          bad_name, too_long, is_set, is_match, hdr_done, we_last;

	dmf_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready = (sq_q == SQ_RX);
	assign rx_acc   = in_valid && in_ready;
	assign eol      = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign ld       = !out_valid || out_ready;
	assign rbyte    = zero_q ? 8'd0 : rd_data;
	assign dlen     = acc_q[143:112];
	assign bad_name = (nlen_q == 16'd0) || (nlen_q > {9'd0, NAME_MAX});
	assign too_long = ({17'd0, nlen_q} + {1'b0, dlen}) > TOTAL_MAX;
	assign is_set   = (len_q > 8'd8) && (acc_q[143:80] == PFX_SETDATA);
	assign is_match = (len_q > 8'd7) && (acc_q[135:80] == PFX_MATCH);
	assign hdr_done = txt_q ? !(is_set || is_match) : (bad_name || too_long);
	assign we_last  = (rem_q == 8'd0) && !(rpart_q == PART_NAME && dlen != 32'd0);
	assign fa_addr  = txt_q ? {4'd0, f_q} :
		(f_q == 5'd0) ? 9'd1 :
		(f_q == 5'd1) ? 9'd2 : nlen_q[8:0] + {4'd0, f_q} + 9'd1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (rx_acc) begin
			unique case (mode_q)
				MODE_BIN: begin
					wr_en   = 1'b1;
					wr_addr = cnt_q;
				end
				MODE_TEXT: begin
					wr_en   = !eol && ({1'b0, cnt_q} < LINE_TOP);
					wr_addr = cnt_q;
				end
				default: begin
					wr_en   = !eol;
					wr_addr = '0;
				end
			endcase
		end
		if (sq_q == SQ_FA) begin
			rd_en   = 1'b1;
			rd_addr = fa_addr[7:0];
		end else if (sq_q == SQ_WA) begin
			rd_en   = 1'b1;
			rd_addr = w_addr_q[7:0];
		end
	end

	always_comb begin
		sq_d = sq_q;
		unique case (sq_q)
			SQ_RX: begin
				if (rx_acc && mode_q == MODE_BIN && ({1'b0, cnt_q} + 9'd1) >= FRAME_N) begin
					sq_d = SQ_FA;
				end else if (rx_acc && mode_q == MODE_TEXT && eol) begin
					sq_d = SQ_FA;
				end
			end
			SQ_FA: sq_d = SQ_FD;
			SQ_FD: begin
				if (txt_q ? (f_q == 5'd7) : (f_q == 5'd17)) begin
					sq_d = SQ_HDR;
				end else begin
					sq_d = SQ_FA;
				end
			end
			SQ_HDR: begin
				if (ld) begin
					sq_d = hdr_done ? SQ_RX : SQ_WA;
				end
			end
			SQ_WA: sq_d = SQ_WD;
			SQ_WD: begin
				if (wb_q == 4'd7 || rem_q == 8'd1) begin
					sq_d = SQ_WE;
				end else begin
					sq_d = SQ_WA;
				end
			end
			SQ_WE: begin
				if (ld) begin
					sq_d = we_last ? SQ_RX : SQ_WA;
				end
			end
			default: sq_d = SQ_RX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q      <= SQ_RX;
			mode_q    <= MODE_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			sq_q <= sq_d;
			if ((sq_q == SQ_HDR || sq_q == SQ_WE) && ld) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (rx_acc) begin
				unique case (mode_q)
					MODE_BIN: begin
						if (({1'b0, cnt_q} + 9'd1) >= FRAME_N) begin
							mode_q <= MODE_IDLE;
							cnt_q  <= '0;
						end else begin
							cnt_q <= cnt_q + 8'd1;
						end
					end
					MODE_TEXT: begin
						if (!eol && ({1'b0, cnt_q} < LINE_TOP)) begin
							cnt_q <= cnt_q + 8'd1;
						end else begin
							mode_q <= MODE_IDLE;
							cnt_q  <= '0;
						end
					end
					default: begin
						if (rx_byte == CH_START) begin
							mode_q <= MODE_BIN;
							cnt_q  <= 8'd1;
						end else if (!eol) begin
							mode_q <= MODE_TEXT;
							cnt_q  <= 8'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sq_q == SQ_RX && rx_acc) begin
			txt_q <= (mode_q == MODE_TEXT);
			len_q <= cnt_q;
			f_q   <= '0;
		end
		if (sq_q == SQ_FA) begin
			zero_q <= !txt_q && (fa_addr >= FRAME_N);
		end
		if (sq_q == SQ_FD) begin
			acc_q <= {rbyte, acc_q[143:8]};
			f_q   <= f_q + 5'd1;
			if (f_q == 5'd1) begin
				nlen_q <= {rbyte, acc_q[143:136]};
			end
		end
		if (sq_q == SQ_WA) begin
			zero_q <= !txt_q && (w_addr_q >= FRAME_N);
		end
		if (sq_q == SQ_WD) begin
			for (int i = 0; i < 8; i++) begin
				if (wb_q == 4'(i)) begin
					w_acc_q[8*i +: 8] <= rbyte;
				end
			end
			wb_q     <= wb_q + 4'd1;
			w_addr_q <= w_addr_q + 9'd1;
			rem_q    <= rem_q - 8'd1;
		end
		if (sq_q == SQ_HDR && ld) begin
			part       <= PART_HDR;
			word       <= '0;
			word_bytes <= '0;
			last       <= hdr_done;
			wb_q       <= '0;
			w_acc_q    <= '0;
			if (txt_q) begin
				stamp       <= '0;
				data_type   <= '0;
				name_length <= '0;
				rpart_q     <= PART_VALUE;
				if (is_set) begin
					kind           <= KIND_SET;
					status         <= ST_OK;
					payload_length <= len_q - 8'd8;
					rkind_q        <= KIND_SET;
					w_addr_q       <= 9'd8;
					rem_q          <= len_q - 8'd8;
				end else if (is_match) begin
					kind           <= KIND_MATCH;
					status         <= ST_OK;
					payload_length <= len_q;
					rkind_q        <= KIND_MATCH;
					w_addr_q       <= 9'd0;
					rem_q          <= len_q;
				end else begin
					kind           <= KIND_OTHER;
					status         <= ST_IGNORED;
					payload_length <= '0;
				end
			end else begin
				kind <= KIND_BIN;
				if (bad_name) begin
					status         <= ST_BAD_NAME;
					name_length    <= '0;
					stamp          <= '0;
					data_type      <= '0;
					payload_length <= '0;
				end else if (too_long) begin
					status         <= ST_TOO_LONG;
					name_length    <= nlen_q[6:0];
					stamp          <= '0;
					data_type      <= '0;
					payload_length <= '0;
				end else begin
					status         <= ST_OK;
					name_length    <= nlen_q[6:0];
					stamp          <= acc_q[79:16];
					data_type      <= acc_q[111:80];
					payload_length <= dlen[7:0];
				end
				rkind_q  <= KIND_BIN;
				rpart_q  <= PART_NAME;
				w_addr_q <= 9'd3;
				rem_q    <= nlen_q[7:0];
			end
		end
		if (sq_q == SQ_WE && ld) begin
			part           <= rpart_q;
			kind           <= rkind_q;
			status         <= ST_OK;
			name_length    <= '0;
			stamp          <= '0;
			data_type      <= '0;
			payload_length <= '0;
			word           <= w_acc_q;
			word_bytes     <= wb_q;
			last           <= we_last;
			wb_q           <= '0;
			w_acc_q        <= '0;
			if (rem_q == 8'd0 && !we_last) begin
				rpart_q  <= PART_VALUE;
				rem_q    <= dlen[7:0];
				w_addr_q <= w_addr_q + 9'd16;
			end
		end
	end

	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == SQ_FD) |-> ($past(sq_q) == SQ_FA))
		else $error("field byte used without a read");
	a_hdr_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && part == PART_HDR) |-> (word_bytes == 4'd0))
		else $error("header carries word bytes");
	a_word_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && part != PART_HDR) |-> (word_bytes != 4'd0 && word_bytes <= 4'd8))
		else $error("word byte count out of range");
	a_no_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == SQ_WD) |-> !in_ready)
		else $error("request taken while draining");
endmodule

// ===== sim/tb_dual_mode_binary_text_framer_core.sv =====
`timescale 1ns / 1ps
module tb_dual_mode_binary_text_framer_core;
	import dmf_pkg::*;

	localparam int FRAME_LEN = FRAME_BYTES_DEF;
	localparam int LINE_LIM  = (LINE_BYTES_DEF < 256) ? LINE_BYTES_DEF : 256;
	localparam int WATCHDOG  = 20000;

	typedef struct packed {
		logic [1:0]  part;
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [6:0]  name_length;
		logic [63:0] stamp;
		logic [31:0] data_type;
		logic [7:0]  payload_length;
		logic [63:0] word;
		logic [3:0]  word_bytes;
		logic        last;
	} frame_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  part;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [6:0]  name_length;
	logic [63:0] stamp;
	logic [31:0] data_type;
	logic [7:0]  payload_length;
	logic [63:0] word;
	logic [3:0]  word_bytes;
	logic        last;

	dual_mode_binary_text_framer_core u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.rx_byte(rx_byte), .out_valid(out_valid), .out_ready(out_ready),
		.part(part), .kind(kind), .status(status), .name_length(name_length),
		.stamp(stamp), .data_type(data_type), .payload_length(payload_length),
		.word(word), .word_bytes(word_bytes), .last(last)
	);

	logic [7:0]  byte_queue[$];
	frame_item_t expected_items[$];
	mode_t       rx_mode;
	int          rx_count;
	logic [7:0]  rx_store[256];
	int          err_count = 0;
	int          bytes_sent = 0;
	int          items_seen = 0;
	int          frames_sent = 0;
	int          lines_sent = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          hold_off = 0;
	bit          stim_done = 0;
	int          quiet_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] frame_byte_at(int idx);
		if (idx >= FRAME_LEN || idx >= 256) return 8'h00;
		return rx_store[idx];
	endfunction

	function automatic logic [63:0] frame_le(int off, int n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++) v |= 64'(frame_byte_at(off + i)) << (8 * i);
		return v;
	endfunction

	task automatic push_item(part_t p, kind_t k, status_t s, int nl, logic [63:0] st,
			logic [31:0] dt, int pl, logic [63:0] w, int wb);
		frame_item_t it;
		it.part = p; it.kind = k; it.status = s; it.name_length = 7'(nl);
		it.stamp = st; it.data_type = dt; it.payload_length = 8'(pl);
		it.word = w; it.word_bytes = 4'(wb); it.last = 1'b0;
		expected_items.push_back(it);
	endtask

	task automatic mark_run_end();
		expected_items[expected_items.size() - 1].last = 1'b1;
	endtask

	task automatic push_words(part_t p, kind_t k, int start, int len, bit framed);
		int pos;
		int n;
		logic [63:0] w;
		pos = 0;
		while (pos < len) begin
			n = (len - pos > 8) ? 8 : len - pos;
			w = '0;
			for (int i = 0; i < n; i++)
				w |= 64'(framed ? frame_byte_at(start + pos + i)
					: ((start + pos + i < 256) ? rx_store[start + pos + i] : 8'h00))
					<< (8 * i);
			push_item(p, k, ST_OK, 0, 0, 0, 0, w, n);
			pos += n;
		end
	endtask

	task automatic decode_frame();
		int nlen;
		int p;
		logic [63:0] st;
		logic [31:0] dt;
		logic [31:0] dlen;
		nlen = int'(frame_le(1, 2));
		if (nlen == 0 || nlen > 100) begin
			push_item(PART_HDR, KIND_BIN, ST_BAD_NAME, 0, 0, 0, 0, 0, 0);
		end else begin
			p = 3 + nlen;
			st = frame_le(p, 8);
			dt = frame_le(p + 8, 4);
			dlen = frame_le(p + 12, 4);
			if (33'(nlen) + 33'(dlen) > 33'd109) begin
				push_item(PART_HDR, KIND_BIN, ST_TOO_LONG, nlen, 0, 0, 0, 0, 0);
			end else begin
				push_item(PART_HDR, KIND_BIN, ST_OK, nlen, st, dt, int'(dlen), 0, 0);
				push_words(PART_NAME, KIND_BIN, 3, nlen, 1);
				push_words(PART_VALUE, KIND_BIN, p + 16, int'(dlen), 1);
			end
		end
		mark_run_end();
	endtask

	function automatic bit line_has_prefix(logic [63:0] pfx, int n);
		for (int i = 0; i < n; i++)
			if (rx_store[i] != pfx[8*i +: 8]) return 0;
		return 1;
	endfunction

	task automatic classify_line(int len);
		if (len > 8 && line_has_prefix(PFX_SETDATA, 8)) begin
			push_item(PART_HDR, KIND_SET, ST_OK, 0, 0, 0, len - 8, 0, 0);
			push_words(PART_VALUE, KIND_SET, 8, len - 8, 0);
		end else if (len > 7 && line_has_prefix({8'h00, PFX_MATCH}, 7)) begin
			push_item(PART_HDR, KIND_MATCH, ST_OK, 0, 0, 0, len, 0, 0);
			push_words(PART_VALUE, KIND_MATCH, 0, len, 0);
		end else begin
			push_item(PART_HDR, KIND_OTHER, ST_IGNORED, 0, 0, 0, 0, 0, 0);
		end
		mark_run_end();
	endtask

	task automatic predict_byte(logic [7:0] b);
		bit eol;
		eol = (b == CH_LF || b == CH_CR);
		case (rx_mode)
			MODE_BIN: begin
				if (rx_count < 256) rx_store[rx_count] = b;
				rx_count++;
				if (rx_count >= FRAME_LEN) begin
					decode_frame();
					rx_mode = MODE_IDLE;
					rx_count = 0;
				end
			end
			MODE_TEXT: begin
				if (eol) begin
					classify_line(rx_count);
					rx_mode = MODE_IDLE;
					rx_count = 0;
				end else if (rx_count < LINE_LIM - 1) begin
					rx_store[rx_count] = b;
					rx_count++;
				end else begin
					rx_mode = MODE_IDLE;
					rx_count = 0;
				end
			end
			default: begin
				rx_mode = MODE_IDLE;
				if (b == CH_START) begin
					rx_mode = MODE_BIN;
					rx_store[0] = b;
					rx_count = 1;
				end else if (!eol) begin
					rx_mode = MODE_TEXT;
					rx_store[0] = b;
					rx_count = 1;
				end
			end
		endcase
	endtask

	task automatic queue_le(logic [63:0] v, int n, inout int used);
		for (int i = 0; i < n; i++) begin
			byte_queue.push_back(v[8*i +: 8]);
			used++;
		end
	endtask

	task automatic queue_frame(int nlen, logic [31:0] dlen, logic [63:0] st,
			logic [31:0] dt, bit noisy);
		int used;
		used = 1;
		byte_queue.push_back(CH_START);
		queue_le(64'(nlen), 2, used);
		for (int i = 0; i < nlen && used < FRAME_LEN; i++) begin
			byte_queue.push_back(8'($urandom_range(32, 126)));
			used++;
		end
		if (used + 16 <= FRAME_LEN) begin
			queue_le(st, 8, used);
			queue_le(64'(dt), 4, used);
			queue_le(64'(dlen), 4, used);
		end
		while (used < FRAME_LEN) begin
			byte_queue.push_back(noisy ? 8'($urandom) : 8'($urandom_range(0, 255)));
			used++;
		end
		frames_sent++;
	endtask

	task automatic queue_text(string s, bit cr);
		for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
		byte_queue.push_back(cr ? CH_CR : CH_LF);
		lines_sent++;
	endtask

	function automatic string random_text(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
		return s;
	endfunction

	task automatic queue_phase_frame(int ph);
		int nl;
		if (ph == 0) begin
			nl = $urandom_range(0, 1) ? 0 : $urandom_range(101, 65535);
			queue_frame(nl, $urandom, {$urandom, $urandom}, $urandom, 1);
		end else begin
			nl = $urandom_range(1, 100);
			queue_frame(nl, $urandom_range(110 - nl, 300), {$urandom, $urandom}, $urandom, 0);
		end
	endtask

	task automatic queue_random_text();
		int sel;
		int n;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			queue_text({"setdata ", random_text($urandom_range(0, 40))}, $urandom_range(0, 1));
		end else if (sel < 70) begin
			queue_text({"%match ", random_text($urandom_range(0, 40))}, $urandom_range(0, 1));
		end else if (sel < 90) begin
			queue_text(random_text($urandom_range(1, 20)), $urandom_range(0, 1));
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) byte_queue.push_back(8'($urandom));
			byte_queue.push_back(CH_LF);
		end
	endtask

	function automatic bit idle_roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(rx_byte);
				bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (byte_queue.size() > 0 && !idle_roll(send_idle_pct)) begin
					in_valid <= 1'b1;
					rx_byte <= byte_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_item_t got;
		frame_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				items_seen++;
				got = {part, kind, status, name_length, stamp, data_type, payload_length,
					word, word_bytes, last};
				if (expected_items.size() == 0) begin
					err_count++;
					$display("%0t: unexpected item %h", $time, got);
				end else begin
					want = expected_items.pop_front();
					if (got !== want) begin
						err_count++;
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
					end
				end
			end
			out_ready <= !hold_off && !idle_roll(recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG && !stim_done) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 5000; i++) begin
			@(posedge clk);
			if (stim_done) break;
			if (i == 200) begin
				hold_off = 1;
				repeat (1500) @(posedge clk);
				hold_off = 0;
			end
		end
	end

	task automatic drain_queue();
		while (byte_queue.size() > 0 || in_valid) @(posedge clk);
		while (expected_items.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		rx_mode = MODE_IDLE;
		rx_count = 0;
		foreach (rx_store[i]) rx_store[i] = 8'h00;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		byte_queue.push_back(CH_CR);
		byte_queue.push_back(CH_LF);
		queue_frame(100, 9, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 0);
		queue_text("setdata ", 0);
		queue_text("setdata x", 1);
		queue_text("%match ", 0);
		queue_text("%match a", 1);
		queue_text("hello", 0);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 76 : 0;
			recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 17 : 0;
			if (ph < 2) begin
				queue_phase_frame(ph);
				for (int i = 0; i < 2; i++) queue_random_text();
			end else begin
				for (int i = 0; i < 4; i++) queue_random_text();
			end
			drain_queue();
		end

		stim_done = 1;
		$display("Sent %0d bytes (%0d frames, %0d lines), checked %0d output items.",
			bytes_sent, frames_sent, lines_sent, items_seen);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
